// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the column destripe filter.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CDF_ASSERT(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("concurrent assertion failed");
`define CDF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("concurrent assertion failed");
`else
`define CDF_ASSERT(lbl, clk, rst, cond)
`define CDF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/cdf_pkg.sv =====
// Package of the column destripe filter: sizes, command and register codes,
// and the sequencer state type. No dependencies.
package cdf_pkg;

  localparam int MAX_COLUMNS   = 4096;
  localparam int MAX_CHANNELS  = 4;
  localparam int MAX_WINDOW    = 100;
  localparam int CORR_CHANNELS = 3;
  localparam int FRAC_BITS     = 10;

  localparam int COL_W   = 12;
  localparam int CH_W    = 2;
  localparam int SMP_W   = 8;
  localparam int CMD_W   = 2;
  localparam int ADDR_W  = COL_W + CH_W;
  localparam int DEPTH   = MAX_COLUMNS * MAX_CHANNELS;
  localparam int SUM_W   = 20;
  localparam int CORR_W  = 32;
  localparam int ACC_W   = 27;
  localparam int DIV_W   = 31;
  localparam int TDATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACC     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CORRECT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HISTO    = 2'd3;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CINIT, S_PRE_RD, S_PRE_ADD, S_COL_RD, S_COL_S, S_DIV1,
    S_MID, S_DIV2, S_WR, S_ADD_RD, S_ADD, S_SUB_RD, S_SUB, S_NEXT
  } state_t;

endpackage

// ===== rtl/column_destripe_filter.sv =====
// Column destripe filter: per-column sums, mean-ratio corrections, sample correction.
// Uses cdf_pkg and the assertion macros of assert_macros.svh.
// A correct transaction's result passes the a and b registers and the output queue before
// it is offered. Accumulate and correct transactions are accepted one per cycle while the
// sequencer is idle and fewer than four corrections are pending; a clear sweeps the sum
// memory; a compute pass sums a window prefix per channel, then per column runs up to two
// 31-step serial divisions. Reset: synchronous; registers go to 1, 3, 36, 0 and a clearing
// pass of the sum memory runs before the first transaction is accepted.
`include "assert_macros.svh"

module column_destripe_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: column[11:0], channel[13:12], sample[21:14], zero fill
  input  logic [cdf_pkg::TDATA_W-1:0]       s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [cdf_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: out_sample[7:0], out_column[19:8], out_channel[21:20], zero fill
  output logic [cdf_pkg::TDATA_W-1:0]       m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [cdf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cdf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cdf_pkg::*;

  // configuration registers
  logic [12:0] image_columns;
  logic [2:0]  channels;
  logic [6:0]  window_width;
  logic        histogram_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_columns  <= 13'd1;
      channels       <= 3'd3;
      window_width   <= 7'd36;
      histogram_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMNS:  image_columns  <= cfg_data;
        REG_CHANNELS: channels       <= cfg_data[2:0];
        REG_WINDOW:   window_width   <= cfg_data[6:0];
        REG_HISTO:    histogram_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective settings
  logic [12:0] eff_cols;
  logic [2:0]  eff_chans;
  logic [1:0]  nk;
  logic [6:0]  win_c;
  logic [5:0]  half;

  always_comb begin
    eff_cols  = (image_columns > 13'(MAX_COLUMNS)) ? 13'(MAX_COLUMNS) : image_columns;
    eff_chans = (channels > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : channels;
    nk        = (eff_chans > 3'(CORR_CHANNELS)) ? 2'(CORR_CHANNELS) : eff_chans[1:0];
    if (window_width < 7'd2) win_c = 7'd2;
    else if (window_width > 7'(MAX_WINDOW)) win_c = 7'(MAX_WINDOW);
    else win_c = window_width;
    half = win_c[6:1];
  end

  // input fields
  logic [CMD_W-1:0] in_cmd;
  logic [COL_W-1:0] in_col;
  logic [CH_W-1:0]  in_ch;
  logic [SMP_W-1:0] in_v;
  logic             in_region;
  logic             accept;

  assign in_cmd    = s_axis_tuser;
  assign in_col    = s_axis_tdata[11:0];
  assign in_ch     = s_axis_tdata[13:12];
  assign in_v      = s_axis_tdata[21:14];
  assign in_region = ({1'b0, in_col} < eff_cols) && ({1'b0, in_ch} < eff_chans);
  assign accept    = s_axis_tvalid && s_axis_tready;

  state_t state, state_next;
  logic [2:0] pending;

  assign s_axis_tready = (state == S_IDLE) && (pending < 3'd4);

  // sequencer registers
  logic [ADDR_W-1:0] clr_addr;
  logic [1:0]        k;
  logic [12:0]       j;
  logic [12:0]       x;
  logic [ACC_W-1:0]  acc;
  logic [SUM_W-1:0]  s_cur;
  logic              neg;
  logic              szero;

  // serial divider registers
  logic [SUM_W-1:0]  dv_rem;
  logic [DIV_W-1:0]  dv_q;
  logic [SUM_W-1:0]  dv_d;
  logic [4:0]        dv_n;
  logic [SUM_W:0]    dv_sh;
  logic              dv_ge;

  assign dv_sh = {dv_rem, dv_q[DIV_W-1]};
  assign dv_ge = dv_sh >= {1'b0, dv_d};

  // window bounds of the current column
  logic [13:0] j1, add_idx, sub_idx, lo, hi, cnt;
  logic        add_ok, sub_ok;
  logic [12:0] pre_hi;

  always_comb begin
    j1      = {1'b0, j} + 14'd1;
    add_idx = j1 + {8'b0, half};
    add_ok  = add_idx < {1'b0, eff_cols};
    sub_ok  = j1 >= {8'b0, half};
    sub_idx = j1 - {8'b0, half};
    lo      = sub_ok ? sub_idx : 14'd0;
    hi      = (({1'b0, j} + {8'b0, half}) >= {1'b0, eff_cols}) ?
              ({1'b0, eff_cols} - 14'd1) : ({1'b0, j} + {8'b0, half});
    cnt     = hi - lo + 14'd1;
    pre_hi  = ({7'b0, half} >= eff_cols) ? (eff_cols - 13'd1) : {7'b0, half};
  end

  // accumulate pipeline and write forwarding
  logic              p1_valid;
  logic [ADDR_W-1:0] p1_addr;
  logic [SMP_W-1:0]  p1_v;
  logic              wl_valid;
  logic [ADDR_W-1:0] wl_addr;
  logic [SUM_W-1:0]  wl_data;
  logic [SUM_W-1:0]  sum_rdata;
  logic [SUM_W-1:0]  sum_base;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_sat;

  always_comb begin
    sum_base = (wl_valid && (wl_addr == p1_addr)) ? wl_data : sum_rdata;
    sum_add  = {1'b0, sum_base} + {13'b0, p1_v};
    sum_sat  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLR:     if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept && (in_cmd == CMD_CLEAR)) state_next = S_CLR;
        else if (accept && (in_cmd == CMD_COMPUTE) && (nk != 2'd0) &&
                 (eff_cols != 13'd0)) state_next = S_CINIT;
      end
      S_CINIT:   state_next = S_PRE_RD;
      S_PRE_RD:  state_next = S_PRE_ADD;
      S_PRE_ADD: state_next = (x == pre_hi) ? S_COL_RD : S_PRE_RD;
      S_COL_RD:  state_next = S_COL_S;
      S_COL_S:   state_next = S_DIV1;
      S_DIV1:    if (dv_n == 5'd0) state_next = S_MID;
      S_MID:     state_next = (s_cur == '0) ? S_WR : S_DIV2;
      S_DIV2:    if (dv_n == 5'd0) state_next = S_WR;
      S_WR:      state_next = S_ADD_RD;
      S_ADD_RD:  state_next = add_ok ? S_ADD : S_SUB_RD;
      S_ADD:     state_next = S_SUB_RD;
      S_SUB_RD:  state_next = sub_ok ? S_SUB : S_NEXT;
      S_SUB:     state_next = S_NEXT;
      S_NEXT: begin
        if (j1[12:0] != eff_cols) state_next = S_COL_RD;
        else if ((k + 2'd1) == nk) state_next = S_IDLE;
        else state_next = S_CINIT;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else state <= state_next;
  end

  // memory control outputs
  logic [ADDR_W-1:0] sum_raddr, sum_waddr;
  logic [SUM_W-1:0]  sum_wdata;
  logic              sum_we;
  logic              corr_we;
  logic [CORR_W-1:0] corr_wdata;

  always_comb begin
    sum_raddr = {in_col, in_ch};
    case (state)
      S_PRE_RD: sum_raddr = {x[COL_W-1:0], k};
      S_COL_RD: sum_raddr = {j[COL_W-1:0], k};
      S_ADD_RD: sum_raddr = {add_idx[COL_W-1:0], k};
      S_SUB_RD: sum_raddr = {sub_idx[COL_W-1:0], k};
      default:  sum_raddr = {in_col, in_ch};
    endcase
    sum_we    = p1_valid || (state == S_CLR);
    sum_waddr = p1_valid ? p1_addr : clr_addr;
    sum_wdata = p1_valid ? sum_sat : '0;
    corr_we   = (state == S_WR);
    if (szero) corr_wdata = '0;
    else if (neg) corr_wdata = -{1'b0, dv_q};
    else corr_wdata = {1'b0, dv_q};
  end

  // state memories
  logic [SUM_W-1:0]  sum_mem  [DEPTH];
  logic [CORR_W-1:0] corr_mem [DEPTH];
  logic [CORR_W-1:0] corr_rdata;

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sum_rdata <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk) begin
    if (corr_we) corr_mem[{j[COL_W-1:0], k}] <= corr_wdata;
    corr_rdata <= corr_mem[{in_col, in_ch}];
  end

  // accumulate transactions: read on accept, write back in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      wl_valid <= 1'b0;
    end else begin
      p1_valid <= accept && (in_cmd == CMD_ACC) && in_region;
      wl_valid <= p1_valid;
    end
    p1_addr <= {in_col, in_ch};
    p1_v    <= in_v;
    wl_addr <= p1_addr;
    wl_data <= sum_sat;
  end

  // correction sequencer datapath
  logic [SUM_W:0] diff;
  assign diff = {1'b0, dv_q[SUM_W-1:0]} - {1'b0, s_cur};

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLR) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end else if (accept && (in_cmd == CMD_CLEAR)) begin
      clr_addr <= '0;
    end
    case (state)
      S_IDLE:    k <= 2'd0;
      S_CINIT: begin
        acc <= '0;
        x   <= '0;
        j   <= '0;
      end
      S_PRE_ADD: begin
        acc <= acc + {7'b0, sum_rdata};
        x   <= x + 13'd1;
      end
      S_COL_S: begin
        s_cur  <= sum_rdata;
        dv_q   <= {4'b0, acc};
        dv_d   <= {6'b0, cnt};
        dv_rem <= '0;
        dv_n   <= 5'(DIV_W - 1);
        szero  <= 1'b0;
      end
      S_DIV1, S_DIV2: begin
        dv_rem <= dv_ge ? (dv_sh[SUM_W-1:0] - dv_d) : dv_sh[SUM_W-1:0];
        dv_q   <= {dv_q[DIV_W-2:0], dv_ge};
        dv_n   <= dv_n - 5'd1;
      end
      S_MID: begin
        neg    <= diff[SUM_W];
        dv_q   <= {1'b0, (diff[SUM_W] ? 20'(-diff) : diff[SUM_W-1:0]), 10'b0};
        dv_d   <= s_cur;
        dv_rem <= '0;
        dv_n   <= 5'(DIV_W - 1);
        szero  <= (s_cur == '0);
      end
      S_ADD:     acc <= acc + {7'b0, sum_rdata};
      S_SUB:     acc <= acc - {7'b0, sum_rdata};
      S_NEXT: begin
        j <= j1[12:0];
        if (j1[12:0] == eff_cols) k <= k + 2'd1;
      end
      default: ;
    endcase
  end

  // correct transactions: read, multiply, shift and clamp
  logic                     a_valid, a_use;
  logic [SMP_W-1:0]         a_v;
  logic [COL_W-1:0]         a_col;
  logic [CH_W-1:0]          a_ch;
  logic                     b_valid;
  logic signed [40:0]       b_prod;
  logic [SMP_W-1:0]         b_v;
  logic [COL_W-1:0]         b_col;
  logic [CH_W-1:0]          b_ch;
  logic signed [CORR_W-1:0] c_sel;
  logic signed [40:0]       term;
  logic [8:0]               base;
  logic signed [41:0]       rsum;
  logic [SMP_W-1:0]         r_out;

  always_comb begin
    c_sel = a_use ? $signed(corr_rdata) : '0;
    term  = b_prod >>> FRAC_BITS;
    base  = histogram_mode ? 9'd128 : {1'b0, b_v};
    rsum  = {term[40], term} + $signed({33'b0, base});
    if (rsum < 0) r_out = 8'd0;
    else if (rsum > 42'sd255) r_out = 8'd255;
    else r_out = rsum[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= accept && (in_cmd == CMD_CORRECT);
      b_valid <= a_valid;
    end
    a_use  <= in_region && ({1'b0, in_ch} < 3'(CORR_CHANNELS));
    a_v    <= in_v;
    a_col  <= in_col;
    a_ch   <= in_ch;
    b_prod <= $signed({1'b0, a_v}) * c_sel;
    b_v    <= a_v;
    b_col  <= a_col;
    b_ch   <= a_ch;
  end

  // output queue: hold finished results until the master side takes them
  logic [21:0] fifo_mem [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  fifo_cnt;
  logic        pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (fifo_cnt != 3'd0);
  assign m_axis_tdata  = {2'b0, fifo_mem[rd_ptr]};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      pending  <= '0;
    end else begin
      if (b_valid) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fifo_cnt <= fifo_cnt + {2'b0, b_valid} - {2'b0, pop};
      pending  <= pending + {2'b0, accept && (in_cmd == CMD_CORRECT)} - {2'b0, pop};
    end
    if (b_valid) fifo_mem[wr_ptr] <= {b_ch, b_col, r_out};
  end

  // checks
  `CDF_ASSERT(a_queue_le_pending, clk, rst, fifo_cnt <= pending)
  `CDF_ASSERT(a_pending_bound, clk, rst, pending <= 3'd4)
  `CDF_ASSERT(a_no_write_clash, clk, rst, !(p1_valid && (state == S_CLR)))
  `CDF_ASSERT_NEXT(a_corr_enters, clk, rst, accept && (in_cmd == CMD_CORRECT), a_valid)
  `CDF_ASSERT_NEXT(a_no_accept_busy, clk, rst, state != S_IDLE && state_next != S_IDLE,
                   !s_axis_tready)

endmodule
